// ===== hw/rtl/dag_dominator_tree_builder_top_defines.svh =====
// Assertion macros shared by the dominator tree builder RTL.
// Depends on nothing; each macro expects clk and arst_n in the using scope.
`ifndef DAG_DOMINATOR_TREE_BUILDER_TOP_DEFINES_SVH
`define DAG_DOMINATOR_TREE_BUILDER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DAGDT_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dagdt same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DAGDT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dagdt next-cycle check failed");

`endif

// ===== hw/rtl/dagdt_pkg.sv =====
// Types, constants and the sequencer state type of the dominator tree builder.
// Used by dagdt_store and dag_dominator_tree_builder_top.
package dagdt_pkg;

	localparam int NODE_W      = 16;
	localparam int DEPTH_W     = 16;
	localparam int LIFT_LEVELS = 16;
	localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int JT_ADDR_W   = NODE_W + LVL_W;

	localparam logic [LVL_W-1:0]   LVL_LAST  = LVL_W'(LIFT_LEVELS - 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [LVL_W-1:0]   lvl_t;

	typedef struct packed {
		node_t node;
		node_t neighbor;
		logic  has_neighbor;
		logic  last_neighbor;
	} in_item_t;

	typedef struct packed {
		node_t  out_node;
		node_t  dominator;
		depth_t node_level;
	} out_item_t;

	typedef struct packed {
		logic   jrd_en;
		node_t  jrd_node;
		lvl_t   jrd_lvl;
		logic   jwr_en;
		node_t  jwr_node;
		lvl_t   jwr_lvl;
		node_t  jwr_data;
		logic   drd_en;
		node_t  drd_node;
		logic   dwr_en;
		node_t  dwr_node;
		depth_t dwr_data;
	} mem_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DA,
		ST_DB,
		ST_CMP,
		ST_UP,
		ST_UPW,
		ST_CHK,
		ST_DNA,
		ST_DNB,
		ST_DNC,
		ST_FINA,
		ST_FINB,
		ST_INS,
		ST_INSW,
		ST_FRD,
		ST_FWR,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/dagdt_store.sv =====
// Depth store and jump-pointer table with registered reads.
// Depends on dagdt_pkg; the root entries always read as zero.
module dagdt_store
	import dagdt_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output node_t    jrd_data,
	output depth_t   drd_data
);

	logic [NODE_W-1:0]  jmem [2**JT_ADDR_W];
	logic [DEPTH_W-1:0] dmem [2**NODE_W];

	node_t  jrd_raw_q;
	depth_t drd_raw_q;
	logic   jrd_root_q;
	logic   drd_root_q;

	always_ff @(posedge clk) begin
		if (req.jwr_en) begin
			jmem[{req.jwr_node, req.jwr_lvl}] <= req.jwr_data;
		end
		if (req.jrd_en) begin
			jrd_raw_q  <= jmem[{req.jrd_node, req.jrd_lvl}];
			jrd_root_q <= (req.jrd_node == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (req.dwr_en) begin
			dmem[req.dwr_node] <= req.dwr_data;
		end
		if (req.drd_en) begin
			drd_raw_q  <= dmem[req.drd_node];
			drd_root_q <= (req.drd_node == '0);
		end
	end

	assign jrd_data = jrd_root_q ? '0 : jrd_raw_q;
	assign drd_data = drd_root_q ? '0 : drd_raw_q;

endmodule

// ===== hw/rtl/dag_dominator_tree_builder_top.sv =====
// Top level of the dominator tree builder: handshakes, sequencer and output register.
// Depends on dagdt_pkg, dagdt_store and the assertion macro header.
//
// Channel   Direction  Handshake             Payload
// nb        in         nb_valid / nb_ready   nb_item  (in_item_t)
// dom       out        dom_valid / dom_ready dom_item (out_item_t)
//
// An item that neither folds into a meet nor closes a node leaves the sequencer idle.
// A fold into an existing meet is serialised by the single read port of the jump table: it
// reads both depths, then takes one step per level plus one read per lifted bit, then three
// steps per level on the way down.
// Closing a node writes its depth and parent, fills its row level by level, then emits.
// Reset clears only control state; the root entries of both stores read as zero always.
// A full output register stalls the sequencer in its emit step; nb_ready is low meanwhile.
`include "dag_dominator_tree_builder_top_defines.svh"

module dag_dominator_tree_builder_top
	import dagdt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      nb_valid,
	output logic      nb_ready,
	input  in_item_t  nb_item,
	output logic      dom_valid,
	input  logic      dom_ready,
	output out_item_t dom_item
);

	state_t    state_q, state_nx;
	mem_req_t  mem_req;
	node_t     jrd_data;
	depth_t    drd_data;

	node_t     node_q, a_q, b_q, ja_q, meet_q, par_q, w_q;
	logic      last_q, meet_valid_q;
	depth_t    da_q, diff_q, d_q;
	lvl_t      lvl_q;
	logic      dom_valid_q;
	out_item_t dom_item_q;

	logic      nb_fire, emit_load, da_lt_db;
	depth_t    d_sat;

	dagdt_store u_store (
		.clk      (clk),
		.req      (mem_req),
		.jrd_data (jrd_data),
		.drd_data (drd_data)
	);

	assign nb_ready  = (state_q == ST_IDLE);
	assign nb_fire   = nb_valid && nb_ready;
	assign emit_load = (state_q == ST_EMIT) && (!dom_valid_q || dom_ready);
	assign da_lt_db  = (da_q < drd_data);
	assign d_sat     = (drd_data == DEPTH_MAX) ? DEPTH_MAX : drd_data + 1'b1;
	assign dom_valid = dom_valid_q;
	assign dom_item  = dom_item_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (nb_fire && nb_item.node != '0) begin
					if (nb_item.has_neighbor && meet_valid_q) begin
						state_nx = ST_DA;
					end else if (nb_item.last_neighbor) begin
						state_nx = ST_INS;
					end
				end
			end
			ST_DA:   state_nx = ST_DB;
			ST_DB:   state_nx = ST_CMP;
			ST_CMP:  state_nx = ST_UP;
			ST_UP: begin
				if (diff_q[lvl_q]) begin
					state_nx = ST_UPW;
				end else if (lvl_q == LVL_LAST) begin
					state_nx = ST_CHK;
				end
			end
			ST_UPW:  state_nx = (lvl_q == LVL_LAST) ? ST_CHK : ST_UP;
			ST_CHK: begin
				if (a_q == b_q) begin
					state_nx = last_q ? ST_INS : ST_IDLE;
				end else begin
					state_nx = ST_DNA;
				end
			end
			ST_DNA:  state_nx = ST_DNB;
			ST_DNB:  state_nx = ST_DNC;
			ST_DNC:  state_nx = (lvl_q == '0) ? ST_FINA : ST_DNA;
			ST_FINA: state_nx = ST_FINB;
			ST_FINB: state_nx = last_q ? ST_INS : ST_IDLE;
			ST_INS:  state_nx = ST_INSW;
			ST_INSW: state_nx = (LIFT_LEVELS > 1) ? ST_FRD : ST_EMIT;
			ST_FRD:  state_nx = ST_FWR;
			ST_FWR:  state_nx = (lvl_q == LVL_LAST) ? ST_EMIT : ST_FRD;
			ST_EMIT: state_nx = emit_load ? ST_IDLE : ST_EMIT;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_DA: begin
				mem_req.drd_en   = 1'b1;
				mem_req.drd_node = a_q;
			end
			ST_DB: begin
				mem_req.drd_en   = 1'b1;
				mem_req.drd_node = b_q;
			end
			ST_UP: begin
				mem_req.jrd_en   = diff_q[lvl_q];
				mem_req.jrd_node = a_q;
				mem_req.jrd_lvl  = lvl_q;
			end
			ST_DNA: begin
				mem_req.jrd_en   = 1'b1;
				mem_req.jrd_node = a_q;
				mem_req.jrd_lvl  = lvl_q;
			end
			ST_DNB: begin
				mem_req.jrd_en   = 1'b1;
				mem_req.jrd_node = b_q;
				mem_req.jrd_lvl  = lvl_q;
			end
			ST_FINA: begin
				mem_req.jrd_en   = 1'b1;
				mem_req.jrd_node = a_q;
			end
			ST_INS: begin
				mem_req.drd_en   = 1'b1;
				mem_req.drd_node = meet_valid_q ? meet_q : '0;
			end
			ST_INSW: begin
				mem_req.dwr_en   = 1'b1;
				mem_req.dwr_node = node_q;
				mem_req.dwr_data = d_sat;
				mem_req.jwr_en   = 1'b1;
				mem_req.jwr_node = node_q;
				mem_req.jwr_data = par_q;
			end
			ST_FRD: begin
				mem_req.jrd_en   = 1'b1;
				mem_req.jrd_node = w_q;
				mem_req.jrd_lvl  = lvl_q - 1'b1;
			end
			ST_FWR: begin
				mem_req.jwr_en   = 1'b1;
				mem_req.jwr_node = node_q;
				mem_req.jwr_lvl  = lvl_q;
				mem_req.jwr_data = jrd_data;
			end
			default: mem_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			meet_valid_q <= 1'b0;
			dom_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE && nb_fire && nb_item.node != '0 && nb_item.has_neighbor) begin
				meet_valid_q <= 1'b1;
			end else if (state_q == ST_INS) begin
				meet_valid_q <= 1'b0;
			end
			if (emit_load) begin
				dom_valid_q <= 1'b1;
			end else if (dom_ready) begin
				dom_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				node_q <= nb_item.node;
				last_q <= nb_item.last_neighbor;
				a_q    <= meet_q;
				b_q    <= nb_item.neighbor;
				if (nb_fire && nb_item.node != '0 && nb_item.has_neighbor && !meet_valid_q) begin
					meet_q <= nb_item.neighbor;
				end
			end
			ST_DB: da_q <= drd_data;
			ST_CMP: begin
				lvl_q <= '0;
				if (da_lt_db) begin
					a_q    <= b_q;
					b_q    <= a_q;
					diff_q <= drd_data - da_q;
				end else begin
					diff_q <= da_q - drd_data;
				end
			end
			ST_UP: begin
				if (!diff_q[lvl_q] && lvl_q != LVL_LAST) begin
					lvl_q <= lvl_q + 1'b1;
				end
			end
			ST_UPW: begin
				a_q <= jrd_data;
				if (lvl_q != LVL_LAST) begin
					lvl_q <= lvl_q + 1'b1;
				end
			end
			ST_CHK: begin
				meet_q <= a_q;
				lvl_q  <= LVL_LAST;
			end
			ST_DNB: ja_q <= jrd_data;
			ST_DNC: begin
				if (ja_q != jrd_data) begin
					a_q <= ja_q;
					b_q <= jrd_data;
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - 1'b1;
				end
			end
			ST_FINB: meet_q <= jrd_data;
			ST_INS: begin
				par_q  <= meet_valid_q ? meet_q : '0;
				meet_q <= '0;
			end
			ST_INSW: begin
				d_q   <= d_sat;
				w_q   <= par_q;
				lvl_q <= LVL_W'(1);
			end
			ST_FWR: begin
				w_q <= jrd_data;
				if (lvl_q != LVL_LAST) begin
					lvl_q <= lvl_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (emit_load) begin
			dom_item_q.out_node   <= node_q;
			dom_item_q.dominator  <= par_q;
			dom_item_q.node_level <= d_q;
		end
	end

	`DAGDT_ASSERT_NEXT(a_emit_from_seq, !dom_valid_q && !emit_load, !dom_valid_q)
	`DAGDT_ASSERT_SAME(a_no_root_jwr, mem_req.jwr_en, mem_req.jwr_node != '0)
	`DAGDT_ASSERT_SAME(a_no_root_dwr, mem_req.dwr_en, mem_req.dwr_node != '0 && mem_req.dwr_data != '0)
	`DAGDT_ASSERT_NEXT(a_meet_cleared, state_q == ST_INS, !meet_valid_q)

endmodule
